@@ src/aabb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_pkg
// Types, widths and constants shared by the box transform and its interfaces.
// ----------------------------------------------------------------------------
package aabb_pkg;

  localparam int COORD_W    = 32;
  localparam int PROD_W     = 48;
  localparam int SUM_W      = 50;
  localparam int AXES       = 3;
  localparam int PIPE_DEPTH = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic [CFG_DATA_W-1:0]     cfg_word_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_X_LIN = 3'd0,
    REG_ROW_X_ZT  = 3'd1,
    REG_ROW_Y_LIN = 3'd2,
    REG_ROW_Y_ZT  = 3'd3,
    REG_ROW_Z_LIN = 3'd4,
    REG_ROW_Z_ZT  = 3'd5
  } cfg_reg_t;

  localparam cfg_word_t RST_ROW_X_LIN = 64'h0000_0000_0001_0000;
  localparam cfg_word_t RST_ROW_X_ZT  = 64'h0000_0000_0000_0000;
  localparam cfg_word_t RST_ROW_Y_LIN = 64'h0001_0000_0000_0000;
  localparam cfg_word_t RST_ROW_Y_ZT  = 64'h0000_0000_0000_0000;
  localparam cfg_word_t RST_ROW_Z_LIN = 64'h0000_0000_0000_0000;
  localparam cfg_word_t RST_ROW_Z_ZT  = 64'h0000_0000_0001_0000;

  localparam sum_t SUM_MAX = 50'sd2147483647;
  localparam sum_t SUM_MIN = -50'sd2147483648;

  // q16.16 product, floored back to q32.16 (arithmetic shift by 16)
  function automatic prod_t mul_q16(coord_t a, coord_t b);
    logic signed [2*COORD_W-1:0] full;
    full = a * b;
    return full[2*COORD_W-1:16];
  endfunction

  function automatic coord_t sat_coord(sum_t v);
    coord_t r;
    if (v > SUM_MAX) begin
      r = coord_t'(SUM_MAX);
    end else if (v < SUM_MIN) begin
      r = coord_t'(SUM_MIN);
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ src/aabb_box_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_box_in_if
// Input box channel: valid/ready handshake with min and max corner.
// ----------------------------------------------------------------------------
interface aabb_box_in_if import aabb_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t in_min_x;
  coord_t in_min_y;
  coord_t in_min_z;
  coord_t in_max_x;
  coord_t in_max_y;
  coord_t in_max_z;

  modport source (
    output valid, in_min_x, in_min_y, in_min_z, in_max_x, in_max_y, in_max_z,
    input  ready
  );
  modport sink (
    input  valid, in_min_x, in_min_y, in_min_z, in_max_x, in_max_y, in_max_z,
    output ready
  );
endinterface

@@ src/aabb_box_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_box_out_if
// Output box channel: valid/ready handshake with transformed min and max.
// ----------------------------------------------------------------------------
interface aabb_box_out_if import aabb_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t out_min_x;
  coord_t out_min_y;
  coord_t out_min_z;
  coord_t out_max_x;
  coord_t out_max_y;
  coord_t out_max_z;

  modport source (
    output valid, out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z,
    input  ready
  );
  modport sink (
    input  valid, out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z,
    output ready
  );
endinterface

@@ src/aabb_affine_transform.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_affine_transform
// Axis-aligned box through a configured 3x4 affine matrix, q16.16.
//
// Usage:
//   box_in carries one box (min and max corner) per transaction, box_out the
//   tightest box around the eight transformed corners, saturated to q16.16.
//   The matrix sits in six 64-bit registers written over cfg_we / cfg_index /
//   cfg_data; writes must go in only while no transaction is in flight; the
//   block does not enforce it. Five register stages: input, 18 parallel
//   32x32 products, per-term min/max, row sums with translation, saturation
//   into the output register. One box is taken every cycle unless the output
//   stalls; the product stage sets the clock.
//   Each stage holds its own valid bit and advances whenever the stage after
//   it is empty or moving, so a stalled receiver backs the pipe up stage by
//   stage; box_in.ready drops only once every stage is full.
//   Reset clears all valid bits and loads the identity matrix.
// ----------------------------------------------------------------------------
module aabb_affine_transform import aabb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  aabb_box_in_if.sink           box_in,
  aabb_box_out_if.source        box_out
);

  cfg_word_t row_lin [AXES];
  cfg_word_t row_zt  [AXES];

  coord_t coef  [AXES][AXES];
  coord_t trans [AXES];

  logic [PIPE_DEPTH-1:0] vld;
  logic [PIPE_DEPTH-1:0] en;

  coord_t s0_lo [AXES];
  coord_t s0_hi [AXES];
  prod_t  p_lo  [AXES][AXES];
  prod_t  p_hi  [AXES][AXES];
  prod_t  t_lo  [AXES][AXES];
  prod_t  t_hi  [AXES][AXES];
  sum_t   sum_lo [AXES];
  sum_t   sum_hi [AXES];
  coord_t res_lo [AXES];
  coord_t res_hi [AXES];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_lin[0] <= RST_ROW_X_LIN;
      row_zt[0]  <= RST_ROW_X_ZT;
      row_lin[1] <= RST_ROW_Y_LIN;
      row_zt[1]  <= RST_ROW_Y_ZT;
      row_lin[2] <= RST_ROW_Z_LIN;
      row_zt[2]  <= RST_ROW_Z_ZT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_X_LIN: row_lin[0] <= cfg_data;
        REG_ROW_X_ZT:  row_zt[0]  <= cfg_data;
        REG_ROW_Y_LIN: row_lin[1] <= cfg_data;
        REG_ROW_Y_ZT:  row_zt[1]  <= cfg_data;
        REG_ROW_Z_LIN: row_lin[2] <= cfg_data;
        REG_ROW_Z_ZT:  row_zt[2]  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int r = 0; r < AXES; r++) begin
      coef[r][0] = row_lin[r][COORD_W-1:0];
      coef[r][1] = row_lin[r][2*COORD_W-1:COORD_W];
      coef[r][2] = row_zt[r][COORD_W-1:0];
      trans[r]   = row_zt[r][2*COORD_W-1:COORD_W];
    end
  end

  // stage enables: a stage moves when it is empty or its successor moves
  always_comb begin
    en[PIPE_DEPTH-1] = !vld[PIPE_DEPTH-1] || box_out.ready;
    for (int i = PIPE_DEPTH - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= box_in.valid;
      end
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // stage 0: input register
  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_lo[0] <= box_in.in_min_x;
      s0_lo[1] <= box_in.in_min_y;
      s0_lo[2] <= box_in.in_min_z;
      s0_hi[0] <= box_in.in_max_x;
      s0_hi[1] <= box_in.in_max_y;
      s0_hi[2] <= box_in.in_max_z;
    end
  end

  // stage 1: products
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int r = 0; r < AXES; r++) begin
        for (int c = 0; c < AXES; c++) begin
          p_lo[r][c] <= mul_q16(coef[r][c], s0_lo[c]);
          p_hi[r][c] <= mul_q16(coef[r][c], s0_hi[c]);
        end
      end
    end
  end

  // stage 2: order each term
  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int r = 0; r < AXES; r++) begin
        for (int c = 0; c < AXES; c++) begin
          if (p_lo[r][c] < p_hi[r][c]) begin
            t_lo[r][c] <= p_lo[r][c];
            t_hi[r][c] <= p_hi[r][c];
          end else begin
            t_lo[r][c] <= p_hi[r][c];
            t_hi[r][c] <= p_lo[r][c];
          end
        end
      end
    end
  end

  // stage 3: row sums plus translation
  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int r = 0; r < AXES; r++) begin
        sum_lo[r] <= SUM_W'(t_lo[r][0]) + SUM_W'(t_lo[r][1]) + SUM_W'(t_lo[r][2])
                     + SUM_W'(trans[r]);
        sum_hi[r] <= SUM_W'(t_hi[r][0]) + SUM_W'(t_hi[r][1]) + SUM_W'(t_hi[r][2])
                     + SUM_W'(trans[r]);
      end
    end
  end

  // stage 4: saturate into the output register
  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int r = 0; r < AXES; r++) begin
        res_lo[r] <= sat_coord(sum_lo[r]);
        res_hi[r] <= sat_coord(sum_hi[r]);
      end
    end
  end

  assign box_in.ready      = en[0];
  assign box_out.valid     = vld[PIPE_DEPTH-1];
  assign box_out.out_min_x = res_lo[0];
  assign box_out.out_min_y = res_lo[1];
  assign box_out.out_min_z = res_lo[2];
  assign box_out.out_max_x = res_hi[0];
  assign box_out.out_max_y = res_hi[1];
  assign box_out.out_max_z = res_hi[2];

  // checks
  a_reset_clears: assert property (@(posedge clk) rst |=> vld == '0)
    else $error("pipeline valid bits not cleared by reset");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    box_in.valid && box_in.ready |=> vld[0])
    else $error("accepted transaction did not enter the input stage");

  a_full_backpressure: assert property (@(posedge clk) disable iff (rst)
    (&vld) && !box_out.ready |-> !box_in.ready)
    else $error("input ready while every stage is full and output stalled");

  a_out_ordered: assert property (@(posedge clk) disable iff (rst)
    box_out.valid |-> box_out.out_min_x <= box_out.out_max_x
                   && box_out.out_min_y <= box_out.out_max_y
                   && box_out.out_min_z <= box_out.out_max_z)
    else $error("output box min above max");

  a_sat_passthrough: assert property (@(posedge clk) disable iff (rst)
    vld[3] && en[4] && sum_lo[0] <= SUM_MAX && sum_lo[0] >= SUM_MIN
    |=> box_out.out_min_x == $past(sum_lo[0][COORD_W-1:0]))
    else $error("in-range sum altered by saturation");

endmodule

@@ sim/aabb_affine_transform_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_affine_transform_tb
// Streams boxes through the affine box transform under several matrices and
// checks every output box against a predictor of the min/max corner sums,
// with random gaps on the input, random stalls on the output and one long
// output hold-off that backs the pipeline up into the input.
// ----------------------------------------------------------------------------
module aabb_affine_transform_tb;
  import aabb_pkg::*;

  localparam int NUM_REGS      = 6;
  localparam int BOXES_PER_SET = 64;
  localparam int NUM_SETS      = 6;
  localparam int HOLD_AFTER    = 110;
  localparam int HOLD_CYCLES   = 60;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  localparam coord_t Q_MIN  = 32'sh8000_0000;
  localparam coord_t Q_MAX  = 32'sh7fff_ffff;
  localparam coord_t Q_ONE  = 32'sh0001_0000;
  localparam coord_t Q_NEG1 = 32'shffff_0000;
  localparam coord_t Q_HALF = 32'sh0000_8000;
  localparam coord_t Q_LSBN = 32'shffff_ffff;

  typedef enum {MAT_SMALL, MAT_FULL, MAT_EXTREME, MAT_ZERO} mat_kind_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
  } box_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  hold_off;
  logic                  idle_on;

  cfg_word_t mat [NUM_REGS];
  box_t      pending_boxes [$];
  box_t      expected_boxes [$];
  box_t      cur_box;
  int        gap_left;
  int        stall_left;
  int        n_accepted;
  int        errors;

  aabb_box_in_if  box_in_ch ();
  aabb_box_out_if box_out_ch ();

  aabb_affine_transform i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .box_in    (box_in_ch),
    .box_out   (box_out_ch)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic coord_t clamp_q16(longint v);
    coord_t r;
    if (v > longint'(Q_MAX)) begin
      r = Q_MAX;
    end else if (v < longint'(Q_MIN)) begin
      r = Q_MIN;
    end else begin
      r = coord_t'(v);
    end
    return r;
  endfunction

  function automatic box_t transform_box(box_t b);
    box_t      r;
    coord_t    lo [AXES];
    coord_t    hi [AXES];
    coord_t    coef [AXES];
    coord_t    res_lo [AXES];
    coord_t    res_hi [AXES];
    cfg_word_t lin;
    cfg_word_t zt;
    longint    p;
    longint    q;
    longint    sum_lo;
    longint    sum_hi;
    lo[0] = b.min_x;
    lo[1] = b.min_y;
    lo[2] = b.min_z;
    hi[0] = b.max_x;
    hi[1] = b.max_y;
    hi[2] = b.max_z;
    for (int row = 0; row < AXES; row++) begin
      lin     = mat[2*row];
      zt      = mat[2*row+1];
      coef[0] = lin[31:0];
      coef[1] = lin[63:32];
      coef[2] = zt[31:0];
      sum_lo  = longint'(coord_t'(zt[63:32]));
      sum_hi  = sum_lo;
      for (int c = 0; c < AXES; c++) begin
        // floor of the exact q32.32 product back to q32.16
        p = (longint'(coef[c]) * longint'(lo[c])) >>> 16;
        q = (longint'(coef[c]) * longint'(hi[c])) >>> 16;
        if (p < q) begin
          sum_lo += p;
          sum_hi += q;
        end else begin
          sum_lo += q;
          sum_hi += p;
        end
      end
      res_lo[row] = clamp_q16(sum_lo);
      res_hi[row] = clamp_q16(sum_hi);
    end
    r.min_x = res_lo[0];
    r.min_y = res_lo[1];
    r.min_z = res_lo[2];
    r.max_x = res_hi[0];
    r.max_y = res_hi[1];
    r.max_z = res_hi[2];
    return r;
  endfunction

  function automatic coord_t rand_coord();
    coord_t v;
    case ($urandom_range(0, 7))
      0:       v = Q_MIN;
      1:       v = Q_MAX;
      2, 3:    v = $urandom;
      default: v = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    endcase
    return v;
  endfunction

  function automatic box_t rand_box();
    box_t   b;
    coord_t a [AXES];
    coord_t z [AXES];
    coord_t t;
    bit     ordered;
    ordered = ($urandom_range(0, 99) < 85);
    for (int c = 0; c < AXES; c++) begin
      a[c] = rand_coord();
      z[c] = rand_coord();
      if (ordered && a[c] > z[c]) begin
        t    = a[c];
        a[c] = z[c];
        z[c] = t;
      end
    end
    b.min_x = a[0];
    b.min_y = a[1];
    b.min_z = a[2];
    b.max_x = z[0];
    b.max_y = z[1];
    b.max_z = z[2];
    return b;
  endfunction

  function automatic coord_t rand_coef(mat_kind_t kind);
    coord_t v;
    case (kind)
      MAT_SMALL: v = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      MAT_FULL:  v = $urandom;
      MAT_EXTREME: begin
        case ($urandom_range(0, 4))
          0:       v = Q_MIN;
          1:       v = Q_MAX;
          2:       v = '0;
          3:       v = Q_LSBN;
          default: v = Q_ONE;
        endcase
      end
      default:   v = '0;
    endcase
    return v;
  endfunction

  function automatic coord_t rand_offset(mat_kind_t kind);
    coord_t v;
    if (kind == MAT_ZERO) begin
      v = $urandom;
    end else begin
      v = rand_coef(kind);
    end
    return v;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, cfg_word_t val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx <= REG_ROW_Z_ZT) begin
      mat[idx] = val;
    end
  endtask

  task automatic finish_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_matrix(mat_kind_t kind);
    write_reg(REG_ROW_X_LIN, {rand_coef(kind), rand_coef(kind)});
    write_reg(REG_ROW_X_ZT,  {rand_offset(kind), rand_coef(kind)});
    write_reg(REG_ROW_Y_LIN, {rand_coef(kind), rand_coef(kind)});
    write_reg(REG_ROW_Y_ZT,  {rand_offset(kind), rand_coef(kind)});
    write_reg(REG_ROW_Z_LIN, {rand_coef(kind), rand_coef(kind)});
    write_reg(REG_ROW_Z_ZT,  {rand_offset(kind), rand_coef(kind)});
    finish_writes();
  endtask

  task automatic push_box(coord_t lx, coord_t ly, coord_t lz,
                          coord_t hx, coord_t hy, coord_t hz);
    box_t b;
    b.min_x = lx;
    b.min_y = ly;
    b.min_z = lz;
    b.max_x = hx;
    b.max_y = hy;
    b.max_z = hz;
    pending_boxes.push_back(b);
  endtask

  task automatic wait_idle();
    while (pending_boxes.size() != 0 || box_in_ch.valid || expected_boxes.size() != 0) begin
      @(negedge clk);
    end
    repeat (PIPE_DEPTH + 2) @(negedge clk);
  endtask

  task automatic check_coord(string name, coord_t want, coord_t got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      box_in_ch.valid <= 1'b0;
    end else begin
      if (box_in_ch.valid && box_in_ch.ready) begin
        expected_boxes.push_back(transform_box(cur_box));
        n_accepted++;
      end
      if (!box_in_ch.valid || box_in_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          box_in_ch.valid <= 1'b0;
        end else if (pending_boxes.size() != 0) begin
          cur_box = pending_boxes.pop_front();
          box_in_ch.in_min_x <= cur_box.min_x;
          box_in_ch.in_min_y <= cur_box.min_y;
          box_in_ch.in_min_z <= cur_box.min_z;
          box_in_ch.in_max_x <= cur_box.max_x;
          box_in_ch.in_max_y <= cur_box.max_y;
          box_in_ch.in_max_z <= cur_box.max_z;
          box_in_ch.valid    <= 1'b1;
          if (idle_on && !hold_off && $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(1, 18);
          end
        end else begin
          box_in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // output monitor
  always @(posedge clk) begin
    box_t want;
    if (rst) begin
      box_out_ch.ready <= 1'b0;
    end else begin
      if (box_out_ch.valid && box_out_ch.ready) begin
        if (expected_boxes.size() == 0) begin
          $error("output transaction with no box pending");
          errors++;
        end else begin
          want = expected_boxes.pop_front();
          check_coord("out_min_x", want.min_x, box_out_ch.out_min_x);
          check_coord("out_min_y", want.min_y, box_out_ch.out_min_y);
          check_coord("out_min_z", want.min_z, box_out_ch.out_min_z);
          check_coord("out_max_x", want.max_x, box_out_ch.out_max_x);
          check_coord("out_max_y", want.max_y, box_out_ch.out_max_y);
          check_coord("out_max_z", want.max_z, box_out_ch.out_max_z);
        end
      end
      if (stall_left != 0) begin
        stall_left--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 18);
      end
      box_out_ch.ready <= !hold_off && (stall_left == 0);
    end
  end

  // long receiver hold-off so the pipe fills and input ready drops
  initial begin
    hold_off = 1'b0;
    while (n_accepted < HOLD_AFTER) begin
      @(negedge clk);
    end
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    int waited;
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    idle_on             = 1'b1;
    gap_left            = 0;
    stall_left          = 0;
    n_accepted          = 0;
    errors              = 0;
    box_in_ch.valid     = 1'b0;
    box_in_ch.in_min_x  = '0;
    box_in_ch.in_min_y  = '0;
    box_in_ch.in_min_z  = '0;
    box_in_ch.in_max_x  = '0;
    box_in_ch.in_max_y  = '0;
    box_in_ch.in_max_z  = '0;
    box_out_ch.ready    = 1'b0;
    mat[REG_ROW_X_LIN]  = RST_ROW_X_LIN;
    mat[REG_ROW_X_ZT]   = RST_ROW_X_ZT;
    mat[REG_ROW_Y_LIN]  = RST_ROW_Y_LIN;
    mat[REG_ROW_Y_ZT]   = RST_ROW_Y_ZT;
    mat[REG_ROW_Z_LIN]  = RST_ROW_Z_LIN;
    mat[REG_ROW_Z_ZT]   = RST_ROW_Z_ZT;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // identity matrix out of reset
    push_box('0, '0, '0, '0, '0, '0);
    push_box(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
             32'sh0004_0000, 32'sh0005_0000, 32'sh0006_0000);
    push_box(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    push_box(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    push_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
    push_box(32'sh0005_0000, Q_NEG1, 32'sh0007_0000,
             32'shfffb_0000, Q_ONE, 32'shfff9_0000);
    push_box(32'sh0000_0001, Q_LSBN, Q_HALF, 32'sh0000_0003, 32'sh0000_0001, 32'sh0001_8000);
    wait_idle();

    // saturating rows, with writes to unused indexes mixed in
    write_reg(REG_SPARE_6, 64'hffff_ffff_ffff_ffff);
    write_reg(REG_ROW_X_LIN, {Q_MAX, Q_MAX});
    write_reg(REG_ROW_X_ZT,  {Q_MAX, Q_MAX});
    write_reg(REG_ROW_Y_LIN, {Q_MIN, Q_MIN});
    write_reg(REG_ROW_Y_ZT,  {Q_MIN, Q_MIN});
    write_reg(REG_ROW_Z_LIN, {Q_NEG1, Q_HALF});
    write_reg(REG_ROW_Z_ZT,  {Q_ONE, Q_LSBN});
    write_reg(REG_SPARE_7, {$urandom, $urandom});
    finish_writes();
    push_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
    push_box(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    push_box(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    push_box('0, '0, '0, '0, '0, '0);
    push_box(32'sh0000_0001, Q_LSBN, Q_HALF, 32'sh0000_0003, 32'sh0000_0001, 32'sh0001_8000);
    push_box(32'sh0005_0000, Q_NEG1, 32'sh0007_0000,
             32'shfffb_0000, Q_ONE, 32'shfff9_0000);
    wait_idle();

    // quarter turn about z, scaled z, with offsets
    write_reg(REG_ROW_X_LIN, {Q_NEG1, 32'sh0000_0000});
    write_reg(REG_ROW_X_ZT,  {32'sh0003_0000, 32'sh0000_0000});
    write_reg(REG_ROW_Y_LIN, {32'sh0000_0000, Q_ONE});
    write_reg(REG_ROW_Y_ZT,  {32'shfffd_8000, 32'sh0000_0000});
    write_reg(REG_ROW_Z_LIN, {32'sh0000_0000, 32'sh0000_0000});
    write_reg(REG_ROW_Z_ZT,  {32'sh0000_0000, 32'sh0002_0000});
    finish_writes();
    push_box(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
             32'sh0004_0000, 32'sh0005_0000, 32'sh0006_0000);
    push_box(32'sh0005_0000, Q_NEG1, 32'sh0007_0000,
             32'shfffb_0000, Q_ONE, 32'shfff9_0000);
    push_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
    push_box(32'sh0000_0001, Q_LSBN, Q_HALF, 32'sh0000_0003, 32'sh0000_0001, 32'sh0001_8000);
    wait_idle();

    // random boxes under a series of matrices
    for (int grp = 0; grp < NUM_SETS; grp++) begin
      random_matrix(mat_kind_t'(grp % 4));
      if (grp == NUM_SETS - 1) begin
        idle_on = 1'b0;
      end
      for (int i = 0; i < BOXES_PER_SET; i++) begin
        pending_boxes.push_back(rand_box());
      end
      if (grp != NUM_SETS - 1) begin
        wait_idle();
      end
    end

    while (pending_boxes.size() != 0 || box_in_ch.valid) begin
      @(negedge clk);
    end
    waited = 0;
    while (expected_boxes.size() != 0 && waited < 2000) begin
      @(negedge clk);
      waited++;
    end
    repeat (2 * PIPE_DEPTH) @(negedge clk);
    if (expected_boxes.size() != 0) begin
      $error("%0d boxes never came out", expected_boxes.size());
      errors++;
    end
    if (errors == 0) begin
      $display("aabb_affine_transform_tb: PASS");
    end else begin
      $display("aabb_affine_transform_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("aabb_affine_transform_tb: FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
src/aabb_pkg.sv
src/aabb_box_in_if.sv
src/aabb_box_out_if.sv
src/aabb_affine_transform.sv
sim/aabb_affine_transform_tb.sv
